// ----- sv/vfd_pkg.sv -----
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types and constants of the video frame decoder.
// ----------------------------------------------------------------------------
package vfd_pkg;

   localparam int WP_W = 31;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [18:0] row_address;
      logic [7:0]  pixel_a;
      logic [7:0]  pixel_b;
      logic [7:0]  pixel_c;
      logic [7:0]  pixel_d;
      logic        write_enable;
      logic        bad_frame;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic            bad;
      logic            raw;
      logic [WP_W-1:0] wp;
      logic [1:0]      y_base;
      logic [1:0]      y_last;
      logic [15:0]     pat;
      logic [7:0]      c1;
      logic [7:0]      c2;
      logic [31:0]     pix;
   } job_type;

   localparam logic [3:0] PH_FLAG     = 4'd0;
   localparam logic [3:0] PH_CNT_LO   = 4'd1;
   localparam logic [3:0] PH_CNT_HI   = 4'd2;
   localparam logic [3:0] PH_OFFSET   = 4'd3;
   localparam logic [3:0] PH_BLKCOUNT = 4'd4;
   localparam logic [3:0] PH_SOLID    = 4'd5;
   localparam logic [3:0] PH_PAT_C1   = 4'd6;
   localparam logic [3:0] PH_PAT_C2   = 4'd7;
   localparam logic [3:0] PH_PAT_LO   = 4'd8;
   localparam logic [3:0] PH_PAT_HI   = 4'd9;
   localparam logic [3:0] PH_RAW      = 4'd10;
   localparam logic [3:0] PH_PACK_C   = 4'd11;
   localparam logic [3:0] PH_PACK_LO  = 4'd12;
   localparam logic [3:0] PH_PACK_HI  = 4'd13;
   localparam logic [3:0] PH_ABORTED  = 4'd14;

   localparam logic [19:0] BAND_LINE_CAP = 20'hFFFFC;
   localparam logic [1:0]  REG_FRAME_WIDTH = 2'd0;

endpackage

// ----- sv/vfd_front.sv -----
// ----------------------------------------------------------------------------
// vfd_front
// Byte parser: tracks bands, passes and runs, issues row jobs.
// ----------------------------------------------------------------------------
module vfd_front #(
   parameter int RUN_COUNT_LIMIT = 160
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  vfd_pkg::req_type in_data,
   input  logic [9:0]       frame_width,
   output logic             job_push,
   output vfd_pkg::job_type job_data
);
   import vfd_pkg::*;

   logic [3:0]      phase_ff, phase_in;
   logic [3:0]      flags_ff, flags_in;
   logic [1:0]      apass_ff, apass_in;
   logic [19:0]     band_ff, band_in;
   logic [WP_W-1:0] wp_ff, wp_in;
   logic [7:0]      runs_ff, runs_in;
   logic [7:0]      blocks_ff, blocks_in;
   logic [7:0]      c1_ff, c1_in, c2_ff, c2_in, held_ff, held_in;
   logic [3:0]      ridx_ff, ridx_in;
   logic [23:0]     rawb_ff, rawb_in;

   logic [29:0]     band_base;
   logic [7:0]      b;
   logic [15:0]     cnt_v, cnt_mag;
   logic [3:0]      sp_flags;
   logic [2:0]      sp_from;
   logic            sp_go, eb_go, er_go;

   assign b = in_data.data_byte;
   assign band_base = band_ff * frame_width;
   assign cnt_v = {b, held_ff};
   assign cnt_mag = cnt_v[15] ? (16'd0 - cnt_v) : cnt_v;

   function automatic logic [3:0] blk_phase(input logic [1:0] p);
      unique case (p)
         2'd0: blk_phase = PH_SOLID;
         2'd1: blk_phase = PH_PAT_C1;
         2'd2: blk_phase = PH_RAW;
         default: blk_phase = PH_PACK_C;
      endcase
   endfunction

   always_comb begin
      logic       found;
      logic [1:0] pidx;
      logic [7:0] bl;
      phase_in = phase_ff; flags_in = flags_ff; apass_in = apass_ff;
      band_in = band_ff; wp_in = wp_ff; runs_in = runs_ff; blocks_in = blocks_ff;
      c1_in = c1_ff; c2_in = c2_ff; held_in = held_ff; ridx_in = ridx_ff;
      rawb_in = rawb_ff;
      sp_go = 1'b0; sp_from = 3'd0; sp_flags = flags_ff;
      eb_go = 1'b0; er_go = 1'b0;
      job_push = 1'b0;
      job_data = '0;
      job_data.wp = wp_ff;
      job_data.y_last = 2'd3;
      found = 1'b0; pidx = 2'd0; bl = blocks_ff;
      if (in_valid) begin
         unique case (phase_ff)
            PH_FLAG: begin
               flags_in = b[3:0];
               sp_flags = b[3:0];
               sp_go = 1'b1;
            end
            PH_CNT_LO: begin
               held_in = b;
               phase_in = PH_CNT_HI;
            end
            PH_CNT_HI: begin
               if (cnt_mag >= 16'(RUN_COUNT_LIMIT)) begin
                  phase_in = PH_ABORTED;
                  job_push = 1'b1;
                  job_data = '0;
                  job_data.bad = 1'b1;
               end else if (cnt_mag == 16'd0) begin
                  sp_go = 1'b1;
                  sp_from = {1'b0, apass_ff} + 3'd1;
               end else begin
                  runs_in = cnt_mag[7:0];
                  phase_in = cnt_v[15] ? PH_OFFSET : PH_BLKCOUNT;
               end
            end
            PH_OFFSET: begin
               wp_in = wp_ff + {{(WP_W-10){1'b0}}, b, 2'b00};
               if (runs_ff != 8'd0) runs_in = runs_ff - 8'd1;
               phase_in = PH_BLKCOUNT;
            end
            PH_BLKCOUNT: begin
               blocks_in = b;
               ridx_in = 4'd0;
               if (b == 8'd0) er_go = 1'b1;
               else phase_in = blk_phase(apass_ff);
            end
            PH_SOLID: begin
               job_push = 1'b1;
               job_data.c1 = b;
               job_data.c2 = b;
               eb_go = 1'b1;
            end
            PH_PAT_C1: begin c1_in = b; phase_in = PH_PAT_C2; end
            PH_PAT_C2: begin c2_in = b; phase_in = PH_PAT_LO; end
            PH_PAT_LO: begin held_in = b; phase_in = PH_PAT_HI; end
            PH_PACK_C: begin
               c1_in = {4'd0, b[3:0]};
               c2_in = {4'd0, b[7:4]};
               phase_in = PH_PACK_LO;
            end
            PH_PACK_LO: begin held_in = b; phase_in = PH_PACK_HI; end
            PH_PAT_HI, PH_PACK_HI: begin
               job_push = 1'b1;
               job_data.pat = cnt_v;
               job_data.c1 = c1_ff;
               job_data.c2 = c2_ff;
               eb_go = 1'b1;
            end
            PH_RAW: begin
               if (ridx_ff[1:0] != 2'd3) begin
                  case (ridx_ff[1:0])
                     2'd0: rawb_in[7:0] = b;
                     2'd1: rawb_in[15:8] = b;
                     default: rawb_in[23:16] = b;
                  endcase
                  ridx_in = ridx_ff + 4'd1;
               end else begin
                  job_push = 1'b1;
                  job_data.raw = 1'b1;
                  job_data.pix = {b, rawb_ff};
                  job_data.y_base = ridx_ff[3:2];
                  job_data.y_last = 2'd0;
                  if (ridx_ff == 4'd15) begin
                     ridx_in = 4'd0;
                     eb_go = 1'b1;
                  end else begin
                     ridx_in = ridx_ff + 4'd1;
                  end
               end
            end
            default: ;
         endcase

         if (eb_go) begin
            wp_in = wp_ff + WP_W'(4);
            if (blocks_ff != 8'd0) bl = blocks_ff - 8'd1;
            blocks_in = bl;
            if (bl == 8'd0) er_go = 1'b1;
            else phase_in = blk_phase(apass_ff);
         end
         if (er_go) begin
            if (runs_ff <= 8'd1) begin
               runs_in = 8'd0;
               sp_go = 1'b1;
               sp_from = {1'b0, apass_ff} + 3'd1;
            end else begin
               runs_in = runs_ff - 8'd1;
               phase_in = PH_OFFSET;
            end
         end
         if (sp_go) begin
            for (int p = 3; p >= 0; p--) begin
               if (sp_flags[p] && 3'(p) >= sp_from) begin
                  found = 1'b1;
                  pidx = 2'(p);
               end
            end
            if (found) begin
               apass_in = pidx;
               wp_in = {1'b0, band_base};
               phase_in = PH_CNT_LO;
            end else begin
               if (band_ff < BAND_LINE_CAP) band_in = band_ff + 20'd4;
               phase_in = PH_FLAG;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (in_valid && in_data.last_byte)) begin
         phase_ff <= PH_FLAG; flags_ff <= '0; apass_ff <= '0; band_ff <= '0;
         wp_ff <= '0; runs_ff <= '0; blocks_ff <= '0; c1_ff <= '0; c2_ff <= '0;
         held_ff <= '0; ridx_ff <= '0; rawb_ff <= '0;
      end else begin
         phase_ff <= phase_in; flags_ff <= flags_in; apass_ff <= apass_in;
         band_ff <= band_in; wp_ff <= wp_in; runs_ff <= runs_in;
         blocks_ff <= blocks_in; c1_ff <= c1_in; c2_ff <= c2_in;
         held_ff <= held_in; ridx_ff <= ridx_in; rawb_ff <= rawb_in;
      end
   end

endmodule

// ----- sv/vfd_queue.sv -----
// ----------------------------------------------------------------------------
// vfd_queue
// Two-entry job queue between parser and row writer.
// ----------------------------------------------------------------------------
module vfd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  vfd_pkg::job_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output vfd_pkg::job_type head
);
   import vfd_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("pop from empty queue");

endmodule

// ----- sv/vfd_back.sv -----
// ----------------------------------------------------------------------------
// vfd_back
// Row writer: expands one job into row writes, one per cycle unless out_stall holds them.
// ----------------------------------------------------------------------------
module vfd_back #(
   parameter int FRAME_PIXELS_MAX = 524288
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  vfd_pkg::job_type job,
   input  logic [9:0]       frame_width,
   output logic             job_pop,
   output logic             out_valid,
   output vfd_pkg::rsp_type out_data,
   input  logic             out_stall
);
   import vfd_pkg::*;

   logic [1:0]      row_ff;
   logic            vld_ff;
   rsp_type         data_ff, data_in;
   logic            adv, done;
   logic [1:0]      y;
   logic [3:0]      nib;
   logic [WP_W:0]   addr;

   assign adv = job_valid && (!vld_ff || !out_stall);
   assign done = job.bad || row_ff == job.y_last;
   assign job_pop = adv && done;
   assign y = job.y_base + row_ff;
   assign nib = job.pat[4*y +: 4];
   assign addr = {1'b0, job.wp} +
                 ({{(WP_W-1){1'b0}}, y} * {{(WP_W-9){1'b0}}, frame_width});

   always_comb begin
      data_in = '0;
      data_in.run_last = done;
      if (job.bad) begin
         data_in.bad_frame = 1'b1;
      end else begin
         data_in.row_address = addr[18:0];
         data_in.write_enable = addr <= (WP_W+1)'(FRAME_PIXELS_MAX - 4);
         if (job.raw) begin
            {data_in.pixel_d, data_in.pixel_c, data_in.pixel_b, data_in.pixel_a} = job.pix;
         end else begin
            data_in.pixel_a = nib[0] ? job.c2 : job.c1;
            data_in.pixel_b = nib[1] ? job.c2 : job.c1;
            data_in.pixel_c = nib[2] ? job.c2 : job.c1;
            data_in.pixel_d = nib[3] ? job.c2 : job.c1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0; row_ff <= 2'd0;
      end else begin
         if (adv) begin
            vld_ff <= 1'b1;
            row_ff <= done ? 2'd0 : row_ff + 2'd1;
         end else if (!out_stall) begin
            vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) data_ff <= data_in;
   end

   assign out_valid = vld_ff;
   assign out_data = data_ff;

   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && data_ff.bad_frame) |-> (data_ff.run_last && !data_ff.write_enable))
      else $error("abort status not single");
   a_row_idle: assert property (@(posedge clock) disable iff (reset)
      !job_valid |-> row_ff == 2'd0) else $error("row count without job");
   a_raw_one_row: assert property (@(posedge clock) disable iff (reset)
      (job_valid && job.raw) |-> row_ff == 2'd0) else $error("raw job overran");

endmodule

// ----- sv/block_video_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// block_video_frame_decoder
// Paletted 4x4 block frame decoder: bytes in, 4-pixel row writes out.
// A byte's first row is registered in the job queue, then in the row writer's output.
// Throughput: one byte per cycle while rows flow; rows leave one per cycle
// unless rsp_stall holds them, and a solid or pattern byte makes four row writes.
// A two-entry job queue decouples the parser from the row writer.
// Reset: synchronous; frame_width returns to 432, parse state to band start.
// ----------------------------------------------------------------------------
module block_video_frame_decoder #(
   parameter int FRAME_PIXELS_MAX = 524288,
   parameter int RUN_COUNT_LIMIT  = 160
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vfd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vfd_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import vfd_pkg::*;

   logic [9:0] width_ff;
   logic       push, pop, full, nempty;
   job_type    push_job, head;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2:1] == REG_FRAME_WIDTH) ? {22'd0, width_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 10'd432;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2:1] == REG_FRAME_WIDTH && csr_paddr[0] == 1'b0) begin
         width_ff <= csr_pwdata[9:0];
      end
   end

   assign req_stall = full;

   vfd_front #(.RUN_COUNT_LIMIT(RUN_COUNT_LIMIT)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid && !full),
      .in_data(req_data), .frame_width(width_ff),
      .job_push(push), .job_data(push_job)
   );

   vfd_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_job),
      .pop(pop), .full(full), .not_empty(nempty), .head(head)
   );

   vfd_back #(.FRAME_PIXELS_MAX(FRAME_PIXELS_MAX)) u_back (
      .clock(clock), .reset(reset), .job_valid(nempty), .job(head),
      .frame_width(width_ff), .job_pop(pop),
      .out_valid(rsp_valid), .out_data(rsp_data), .out_stall(rsp_stall)
   );

endmodule

// ----- verif/block_video_frame_decoder_test.sv -----
// ----------------------------------------------------------------------------
// block_video_frame_decoder_test
// Self-checking bench for the paletted 4x4 block frame decoder. A directed
// table covers band flags, every pass, skip offsets, zero counts, an aborted
// frame and writes near the end of the frame store. Random frames follow, built byte by
// byte from the predicted parse state so most of them are well formed. Every
// row write is checked against an in-bench decoder under random idling and
// several frame widths.
// ----------------------------------------------------------------------------
module block_video_frame_decoder_test;
   import vfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_LIMIT = 524288;
   localparam int COUNT_LIMIT = 160;
   localparam int IDLE_LIMIT = 3000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   block_video_frame_decoder u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // decoder state of the bench
   logic [9:0]  width_reg;
   logic [3:0]  parse_ph;
   logic [3:0]  band_flags;
   logic [1:0]  cur_pass;
   logic [31:0] band_row;
   logic [31:0] wr_ptr;
   logic [31:0] runs_rem;
   logic        skip_pending;
   logic [31:0] blocks_rem;
   logic [7:0]  col1;
   logic [7:0]  col2;
   logic [7:0]  low_byte;
   logic [3:0]  raw_idx;
   logic [23:0] raw_bytes;

   rsp_type rows_expected[$];
   int      rows_seen;
   int      bytes_sent;
   int      frames_aborted;
   int      rows_suppressed;
   int      mismatches;
   int      idle_pct;
   int      stall_pct;
   bit      hold_request;
   int      quiet_cycles;

   task automatic clear_parse();
      parse_ph = PH_FLAG;
      band_flags = 0;
      cur_pass = 0;
      band_row = 0;
      wr_ptr = 0;
      runs_rem = 0;
      skip_pending = 0;
      blocks_rem = 0;
      col1 = 0;
      col2 = 0;
      low_byte = 0;
      raw_idx = 0;
      raw_bytes = 0;
   endtask

   task automatic push_row(input logic [1:0] y, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic [7:0] d, ref int n);
      logic [31:0] addr;
      rsp_type     r;
      addr = wr_ptr + 32'(y) * 32'(width_reg);
      r.row_address = addr[18:0];
      r.pixel_a = a;
      r.pixel_b = b;
      r.pixel_c = c;
      r.pixel_d = d;
      r.write_enable = ({32'd0, addr} + 64'd4 <= 64'(ROW_LIMIT));
      r.bad_frame = 1'b0;
      r.run_last = 1'b0;
      if (!r.write_enable) rows_suppressed++;
      rows_expected.push_back(r);
      n++;
   endtask

   task automatic push_pattern(input logic [15:0] pat, ref int n);
      logic [3:0] nib;
      for (int y = 0; y < 4; y++) begin
         nib = pat[4*y +: 4];
         push_row(2'(y), nib[0] ? col2 : col1, nib[1] ? col2 : col1,
                  nib[2] ? col2 : col1, nib[3] ? col2 : col1, n);
      end
   endtask

   task automatic open_pass(input int from);
      for (int p = from; p < 4; p++) begin
         if (band_flags[p]) begin
            cur_pass = 2'(p);
            wr_ptr = band_row * 32'(width_reg);
            skip_pending = 0;
            parse_ph = PH_CNT_LO;
            return;
         end
      end
      if (band_row < 32'(BAND_LINE_CAP)) band_row += 4;
      parse_ph = PH_FLAG;
   endtask

   function automatic logic [3:0] block_entry();
      case (cur_pass)
         2'd0: return PH_SOLID;
         2'd1: return PH_PAT_C1;
         2'd2: return PH_RAW;
         default: return PH_PACK_C;
      endcase
   endfunction

   task automatic close_run();
      skip_pending = 1;
      if (runs_rem <= 1) begin
         runs_rem = 0;
         open_pass(int'(cur_pass) + 1);
      end else begin
         runs_rem--;
         parse_ph = PH_OFFSET;
      end
   endtask

   task automatic close_block();
      wr_ptr += 4;
      if (blocks_rem > 0) blocks_rem--;
      if (blocks_rem == 0) close_run();
      else parse_ph = block_entry();
   endtask

   // Decodes one accepted byte and queues the rows it writes; returns how many.
   task automatic decode_byte(input logic [7:0] b, input logic last, output int n);
      logic [15:0] v;
      logic [15:0] mag;
      int          first;
      n = 0;
      first = rows_expected.size();
      case (parse_ph)
         PH_FLAG: begin
            band_flags = b[3:0];
            open_pass(0);
         end
         PH_CNT_LO: begin
            low_byte = b;
            parse_ph = PH_CNT_HI;
         end
         PH_CNT_HI: begin
            v = {b, low_byte};
            skip_pending = v[15];
            mag = v[15] ? 16'(17'h10000 - 17'(v)) : v;
            if (mag >= COUNT_LIMIT) begin
               parse_ph = PH_ABORTED;
               rows_expected.push_back('{row_address: '0, pixel_a: '0, pixel_b: '0,
                  pixel_c: '0, pixel_d: '0, write_enable: 1'b0, bad_frame: 1'b1,
                  run_last: 1'b0});
               n++;
               frames_aborted++;
            end else if (mag == 0) begin
               open_pass(int'(cur_pass) + 1);
            end else begin
               runs_rem = 32'(mag);
               parse_ph = skip_pending ? PH_OFFSET : PH_BLKCOUNT;
            end
         end
         PH_OFFSET: begin
            wr_ptr += 32'(b) * 4;
            if (runs_rem > 0) runs_rem--;
            parse_ph = PH_BLKCOUNT;
         end
         PH_BLKCOUNT: begin
            blocks_rem = 32'(b);
            raw_idx = 0;
            if (b == 0) close_run();
            else parse_ph = block_entry();
         end
         PH_SOLID: begin
            for (int y = 0; y < 4; y++) push_row(2'(y), b, b, b, b, n);
            close_block();
         end
         PH_PAT_C1: begin
            col1 = b;
            parse_ph = PH_PAT_C2;
         end
         PH_PAT_C2: begin
            col2 = b;
            parse_ph = PH_PAT_LO;
         end
         PH_PAT_LO, PH_PACK_LO: begin
            low_byte = b;
            parse_ph = (parse_ph == PH_PAT_LO) ? PH_PAT_HI : PH_PACK_HI;
         end
         PH_PAT_HI, PH_PACK_HI: begin
            push_pattern({b, low_byte}, n);
            close_block();
         end
         PH_RAW: begin
            if (raw_idx[1:0] != 2'd3) begin
               raw_bytes[8*raw_idx[1:0] +: 8] = b;
               raw_idx++;
            end else begin
               push_row(raw_idx[3:2], raw_bytes[7:0], raw_bytes[15:8], raw_bytes[23:16], b, n);
               if (raw_idx == 4'hF) begin
                  raw_idx = 0;
                  close_block();
               end else begin
                  raw_idx++;
               end
            end
         end
         PH_PACK_C: begin
            col1 = {4'd0, b[3:0]};
            col2 = {4'd0, b[7:4]};
            parse_ph = PH_PACK_LO;
         end
         default: ;
      endcase
      if (n > 0) rows_expected[first + n - 1].run_last = 1'b1;
      if (last) clear_parse();
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // result side: checking, random stall, long hold-off on request
   int hold_left;
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rows_seen++;
            if (rows_expected.size() == 0) begin
               report("unexpected row", 32'(rsp_data.row_address), 0);
            end else begin
               e = rows_expected.pop_front();
               if (rsp_data.row_address !== e.row_address)
                  report("row_address", 32'(rsp_data.row_address), 32'(e.row_address));
               if (rsp_data.pixel_a !== e.pixel_a)
                  report("pixel_a", 32'(rsp_data.pixel_a), 32'(e.pixel_a));
               if (rsp_data.pixel_b !== e.pixel_b)
                  report("pixel_b", 32'(rsp_data.pixel_b), 32'(e.pixel_b));
               if (rsp_data.pixel_c !== e.pixel_c)
                  report("pixel_c", 32'(rsp_data.pixel_c), 32'(e.pixel_c));
               if (rsp_data.pixel_d !== e.pixel_d)
                  report("pixel_d", 32'(rsp_data.pixel_d), 32'(e.pixel_d));
               if (rsp_data.write_enable !== e.write_enable)
                  report("write_enable", 32'(rsp_data.write_enable), 32'(e.write_enable));
               if (rsp_data.bad_frame !== e.bad_frame)
                  report("bad_frame", 32'(rsp_data.bad_frame), 32'(e.bad_frame));
               if (rsp_data.run_last !== e.run_last)
                  report("run_last", 32'(rsp_data.run_last), 32'(e.run_last));
            end
         end
         if (hold_request && hold_left == 0) begin
            hold_left = 400;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic l, output int n);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: d, last_byte: l};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      decode_byte(d, l, n);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (rows_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_width(input logic [9:0] w);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(4 * int'(REG_FRAME_WIDTH));
      csr_pwdata <= {22'($urandom_range(4194303)), w};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      width_reg = w;
      @(posedge clock);
   endtask

   typedef struct {
      logic [7:0] d;
      logic       l;
      bit         typed;
      rsp_type    r;
   } step_row;

   localparam rsp_type ABORT_ROW = '{row_address: '0, pixel_a: '0, pixel_b: '0,
      pixel_c: '0, pixel_d: '0, write_enable: 1'b0, bad_frame: 1'b1, run_last: 1'b1};
   localparam rsp_type NO_ROW = '{default: '0};

   step_row steps[] = '{
      '{8'hF1, 0, 0, NO_ROW},   // high flag bits ignored, solid pass
      '{8'h01, 0, 0, NO_ROW}, '{8'h00, 0, 0, NO_ROW}, '{8'h01, 0, 0, NO_ROW},
      '{8'hFF, 0, 0, NO_ROW},
      '{8'h00, 0, 0, NO_ROW},   // empty band
      '{8'h02, 0, 0, NO_ROW},   // pattern with skip offset
      '{8'hFF, 0, 0, NO_ROW}, '{8'hFF, 0, 0, NO_ROW}, '{8'hFF, 0, 0, NO_ROW},
      '{8'h01, 0, 0, NO_ROW}, '{8'h00, 0, 0, NO_ROW}, '{8'hFF, 0, 0, NO_ROW},
      '{8'hA5, 0, 0, NO_ROW}, '{8'h5A, 0, 0, NO_ROW},
      '{8'h08, 0, 0, NO_ROW}, '{8'h00, 0, 0, NO_ROW}, '{8'h00, 0, 0, NO_ROW},
      '{8'h0C, 0, 0, NO_ROW},   // zero block count, then packed pass is next
      '{8'h01, 0, 0, NO_ROW}, '{8'h00, 0, 0, NO_ROW}, '{8'h00, 0, 0, NO_ROW},
      '{8'hA0, 0, 0, NO_ROW},   // count too large
      '{8'h00, 0, 1, ABORT_ROW},
      '{8'h55, 1, 0, NO_ROW}
   };

   logic [7:0] cnt_hi_next;
   int         frame_left;

   // picks the next byte so that most frames parse deep into the passes
   task automatic pick_byte(output logic [7:0] d, output logic l);
      logic [15:0] cnt;
      int          r;
      d = 8'($urandom);
      case (parse_ph)
         PH_FLAG: d = {4'($urandom), 4'($urandom_range(1, 15))};
         PH_CNT_LO: begin
            r = $urandom_range(29);
            if (r == 0) cnt = 16'($urandom);
            else if (r < 3) cnt = 16'($urandom_range(COUNT_LIMIT, 400));
            else if (r < 5) cnt = 0;
            else cnt = 16'($urandom_range(1, 3));
            if ($urandom_range(1)) cnt = -cnt;
            d = cnt[7:0];
            cnt_hi_next = cnt[15:8];
         end
         PH_CNT_HI: d = cnt_hi_next;
         PH_BLKCOUNT: d = 8'($urandom_range(9) == 0 ? 0 : $urandom_range(1, 2));
         default: ;
      endcase
      frame_left--;
      l = (frame_left <= 0) || (parse_ph == PH_ABORTED && $urandom_range(3) == 0);
      if (l) frame_left = $urandom_range(15, 60);
   endtask

   task automatic random_frames(input int count);
      logic [7:0] d;
      logic       l;
      int         n;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(19) == 0) begin
            d = 8'($urandom);
            l = ($urandom_range(3) == 0);
         end else begin
            pick_byte(d, l);
         end
         if (i == count - 1) l = 1'b1;
         if (l) frame_left = $urandom_range(15, 60);
         send_byte(d, l, n);
      end
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_request = 0;
      quiet_cycles = 0;
      rows_seen = 0;
      bytes_sent = 0;
      frames_aborted = 0;
      rows_suppressed = 0;
      mismatches = 0;
      frame_left = 40;
      width_reg = 10'd432;
      clear_parse();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) begin
         send_byte(steps[i].d, steps[i].l, n);
         if (steps[i].typed) begin
            repeat (n) void'(rows_expected.pop_back());
            rows_expected.push_back(steps[i].r);
         end
      end

      // far bands at the widest stride: rows near the end of the frame store
      write_width(10'd1023);
      idle_pct = 18;
      stall_pct = 18;
      repeat (127) send_byte(8'h00, 1'b0, n);
      send_byte(8'h01, 1'b0, n);
      send_byte(8'hFE, 1'b0, n);
      send_byte(8'hFF, 1'b0, n);
      send_byte(8'hFF, 1'b0, n);
      send_byte(8'h01, 1'b0, n);
      send_byte(8'h33, 1'b0, n);
      send_byte(8'hFF, 1'b0, n);
      send_byte(8'h01, 1'b0, n);
      send_byte(8'h44, 1'b1, n);

      write_width(10'd4);
      idle_pct = 0;
      stall_pct = 0;
      random_frames(40);

      write_width(10'd432);
      idle_pct = 70;
      stall_pct = 0;
      random_frames(35);

      write_width(10'($urandom_range(4, 1023)));
      idle_pct = 0;
      stall_pct = 70;
      hold_request = 1;
      random_frames(5);
      hold_request = 0;
      random_frames(30);

      write_width(10'd1);
      idle_pct = 18;
      stall_pct = 18;
      random_frames(40);

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d bytes, %0d row writes, %0d aborted frames, %0d suppressed rows",
               bytes_sent, rows_seen, frames_aborted, rows_suppressed);
      $display("widths 432, 1023, 4, random and 1; idle and stall mixes including a long hold");
      if (mismatches == 0 && rows_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d rows outstanding", mismatches, rows_expected.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
